// ===== hdl/acl_pkg.sv =====
// shared types, codes and constants of the access check engine
// no dependencies
package acl_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR     = 3'd0,
    MODE_ADD_GROUP = 3'd1,
    MODE_MARK      = 3'd2,
    MODE_ADD_ENTRY = 3'd3,
    MODE_SORT      = 3'd4,
    MODE_CUT       = 3'd5,
    MODE_EVAL      = 3'd6,
    MODE_NOP       = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    CFG_USER      = 3'd0,
    CFG_OWNER     = 3'd1,
    CFG_TOKEN_LVL = 3'd2,
    CFG_OBJ_LABEL = 3'd3,
    CFG_NO_RD_UP  = 3'd4,
    CFG_TAKE_PRIV = 3'd5,
    CFG_NULL_LIST = 3'd6,
    CFG_SPARE     = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY_MASK = 2'd2,
    ST_SPARE      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_INTEGRITY = 3'd1,
    RSN_OWNER     = 3'd2,
    RSN_NULL      = 3'd3,
    RSN_EMPTY     = 3'd4,
    RSN_DENY      = 3'd5,
    RSN_ALLOWS    = 3'd6,
    RSN_EXHAUSTED = 3'd7
  } reason_e;

  typedef enum logic [1:0] {
    M_NONE      = 2'd0,
    M_FULL      = 2'd1,
    M_DENY_ONLY = 2'd2,
    M_SPARE     = 2'd3
  } match_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MARK_RD,
    S_MARK_CHK,
    S_SORT_I,
    S_SORT_E,
    S_SORT_J,
    S_SORT_PUT,
    S_CUT_RD,
    S_CUT_CHK,
    S_OWN_RD,
    S_OWN_CHK,
    S_ORE_RD,
    S_ORE_CHK,
    S_PRE,
    S_WALK_RD,
    S_WALK_CHK,
    S_WG_RD,
    S_WG_CHK,
    S_OUT
  } state_e;

  localparam logic [6:0]  WRITE_KIND      = 7'h6A;
  localparam logic [6:0]  READ_EXEC       = 7'h05;
  localparam logic [6:0]  OWNER_IMPLICIT  = 7'h30;
  localparam logic [6:0]  TAKE_OWNER      = 7'h40;
  localparam logic [15:0] ID_EVERYONE     = 16'd0;
  localparam logic [15:0] ID_OWNER_RIGHTS = 16'd1;

  typedef struct packed {
    logic [15:0] id;
    logic [6:0]  rights;
    logic        deny;
    logic        inh;
  } entry_t;

  typedef struct packed {
    logic [15:0] id;
    logic        deny_only;
  } group_t;

  typedef struct packed {
    logic [1:0] status;
    logic       granted;
    logic [2:0] reason;
    logic [6:0] granted_rights;
    logic [6:0] missing_rights;
    logic [5:0] deciding_entry;
  } rsp_t;

  function automatic logic [1:0] order_class(entry_t e);
    return {e.inh, ~e.deny};
  endfunction

endpackage

// ===== hdl/acl_if.sv =====
// request and response channels of the access check engine
// valid/ready handshake, no dependencies
interface acl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] sid;
  logic [6:0]  rights;
  logic        is_deny;
  logic        inherited;
  logic        keep_inherited;
  modport source (output valid, mode, sid, rights, is_deny, inherited, keep_inherited,
                  input ready);
  modport sink (input valid, mode, sid, rights, is_deny, inherited, keep_inherited,
                output ready);
endinterface

interface acl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       access_granted;
  logic [2:0] decision_reason;
  logic [6:0] granted_rights;
  logic [6:0] missing_rights;
  logic [5:0] deciding_entry;
  modport source (output valid, status, access_granted, decision_reason, granted_rights,
                  missing_rights, deciding_entry, input ready);
  modport sink (input valid, status, access_granted, decision_reason, granted_rights,
                missing_rights, deciding_entry, output ready);
endinterface

// ===== hdl/acl_access_check_engine.sv =====
// access check engine top level: entry and group memories plus sequencer
// depends on acl_pkg and the channel interfaces in acl_if.sv
//
// usage: one request item in on req_i, exactly one response item out on rsp_o.
// config registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// edits that touch at most one slot (clear, append group, append entry) and rejected
// evaluations go straight to the output state. mark deny-only sweeps the group
// memory; cut inheritance sweeps the entry memory. the sort is an insertion sort
// on the entry memory, which has one read and one write port. evaluate sweeps
// groups then entries and walks the entries, and an entry whose id needs a group
// lookup adds a group sweep; all loops run on the registered memory reads.
// one item is worked on at a time; a finished response waits in an output
// register, so a stalled receiver holds the response while the next item is
// accepted and worked on, and the engine waits only when that one is done.
// reset empties both tables and restores config defaults; no clearing pass.
module acl_access_check_engine #(
  parameter int ENTRY_DEPTH = 32,
  parameter int GROUP_DEPTH = 16,
  parameter int ID_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  acl_req_if.sink     req_i,
  acl_rsp_if.source   rsp_o
);
  import acl_pkg::*;

  localparam int EAW = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int ECW = $clog2(ENTRY_DEPTH + 1);
  localparam int GAW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int GCW = $clog2(GROUP_DEPTH + 1);
  localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_BITS) - 64'd1);
  localparam logic [5:0] NO_ENTRY = 6'(ENTRY_DEPTH);

  entry_t e_mem [ENTRY_DEPTH];
  group_t g_mem [GROUP_DEPTH];
  entry_t e_rdata_q, e_wdata;
  group_t g_rdata_q, g_wdata;
  logic [EAW-1:0] e_raddr, e_waddr;
  logic [GAW-1:0] g_waddr;
  logic e_we, g_we;

  state_e state_q, state_d;
  logic [ECW-1:0] idx_q, idx_d, s_q, s_d, n_q, n_d, ecount_q, ecount_d;
  logic [GCW-1:0] gidx_q, gidx_d, gcount_q, gcount_d;
  entry_t cur_q, cur_d;
  logic [6:0]  req_q, req_d, given_q, given_d;
  logic [15:0] sid_q, sid_d;
  logic keep_q, keep_d, own_q, own_d, ore_q, ore_d;
  rsp_t pend_q, pend_d, out_q, out_d;
  logic ov_q, ov_d;

  logic [15:0] user_q, owner_q;
  logic [1:0]  tok_q, lbl_q;
  logic nru_q, priv_q, null_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_q  <= '0;
      owner_q <= '0;
      tok_q   <= 2'd1;
      lbl_q   <= 2'd1;
      nru_q   <= 1'b0;
      priv_q  <= 1'b0;
      null_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USER:      user_q  <= cfg_wdata_i & ID_MASK;
        CFG_OWNER:     owner_q <= cfg_wdata_i & ID_MASK;
        CFG_TOKEN_LVL: tok_q   <= cfg_wdata_i[1:0];
        CFG_OBJ_LABEL: lbl_q   <= cfg_wdata_i[1:0];
        CFG_NO_RD_UP:  nru_q   <= cfg_wdata_i[0];
        CFG_TAKE_PRIV: priv_q  <= cfg_wdata_i[0];
        CFG_NULL_LIST: null_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (e_we) e_mem[e_waddr] <= e_wdata;
    e_rdata_q <= e_mem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) g_mem[g_waddr] <= g_wdata;
    g_rdata_q <= g_mem[gidx_q[GAW-1:0]];
  end

  // shared conditions
  logic in_acc, out_free, e_end, g_end, sort_end, cls_gt, s_last;
  logic e_full, g_full, integ_fail, quick, g_hit, apply_now;
  logic hit_deny, hit_allow, pre_grant;
  logic [6:0] forbid, refused, given_new, pre_given;
  logic [15:0] sid_m;
  entry_t ent_cur;
  match_e m;

  assign in_acc   = req_i.valid && req_i.ready;
  assign out_free = !ov_q || rsp_o.ready;
  assign e_end    = idx_q == ecount_q;
  assign g_end    = gidx_q == gcount_q;
  assign sort_end = idx_q >= ecount_q;
  assign cls_gt   = order_class(e_rdata_q) > order_class(cur_q);
  assign s_last   = s_q == ECW'(1);
  assign e_full   = ecount_q == ECW'(ENTRY_DEPTH);
  assign g_full   = gcount_q == GCW'(GROUP_DEPTH);
  assign sid_m    = req_i.sid & ID_MASK;
  assign forbid   = WRITE_KIND | (nru_q ? READ_EXEC : 7'd0);
  assign integ_fail = (tok_q < lbl_q) && ((req_i.rights & forbid) != 7'd0);

  assign ent_cur  = (state_q == S_WALK_CHK) ? e_rdata_q : cur_q;
  assign quick    = (e_rdata_q.id == ID_EVERYONE) || (e_rdata_q.id == user_q) ||
                    (e_rdata_q.id == ID_OWNER_RIGHTS);
  assign g_hit    = g_rdata_q.id == cur_q.id;

  always_comb begin
    m = M_NONE;
    apply_now = 1'b0;
    case (state_q)
      S_WALK_CHK: begin
        apply_now = quick;
        if ((e_rdata_q.id == ID_EVERYONE) || (e_rdata_q.id == user_q)) m = M_FULL;
        else if (own_q) m = M_FULL;
      end
      S_WG_RD: apply_now = g_end;
      S_WG_CHK: begin
        apply_now = g_hit;
        m = g_rdata_q.deny_only ? M_DENY_ONLY : M_FULL;
      end
      default: ;
    endcase
  end

  assign refused   = ent_cur.rights & req_q & ~given_q;
  assign given_new = given_q | (ent_cur.rights & req_q);
  assign hit_deny  = apply_now && (m != M_NONE) && ent_cur.deny && (refused != 7'd0);
  assign hit_allow = apply_now && (m == M_FULL) && !ent_cur.deny && (given_new == req_q);

  assign pre_given = (req_q & TAKE_OWNER & {7{priv_q}}) |
                     ((own_q && !ore_q) ? (req_q & OWNER_IMPLICIT) : 7'd0);
  assign pre_grant = (pre_given == req_q) || null_q || (ecount_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_i.mode)
            MODE_MARK: state_d = S_MARK_RD;
            MODE_SORT: state_d = S_SORT_I;
            MODE_CUT:  state_d = S_CUT_RD;
            MODE_EVAL: state_d = ((req_i.rights == 7'd0) || integ_fail) ? S_OUT : S_OWN_RD;
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_MARK_RD:  state_d = g_end ? S_OUT : S_MARK_CHK;
      S_MARK_CHK: state_d = S_MARK_RD;
      S_SORT_I:   state_d = sort_end ? S_OUT : S_SORT_E;
      S_SORT_E:   state_d = S_SORT_J;
      S_SORT_J:   state_d = cls_gt ? (s_last ? S_SORT_PUT : S_SORT_J) : S_SORT_I;
      S_SORT_PUT: state_d = S_SORT_I;
      S_CUT_RD:   state_d = e_end ? S_OUT : S_CUT_CHK;
      S_CUT_CHK:  state_d = S_CUT_RD;
      S_OWN_RD:   state_d = g_end ? S_ORE_RD : S_OWN_CHK;
      S_OWN_CHK:  state_d = S_OWN_RD;
      S_ORE_RD:   state_d = e_end ? S_PRE : S_ORE_CHK;
      S_ORE_CHK:  state_d = S_ORE_RD;
      S_PRE:      state_d = pre_grant ? S_OUT : S_WALK_RD;
      S_WALK_RD:  state_d = e_end ? S_OUT : S_WALK_CHK;
      S_WALK_CHK: state_d = !quick ? S_WG_RD : ((hit_deny || hit_allow) ? S_OUT : S_WALK_RD);
      S_WG_RD:    state_d = !g_end ? S_WG_CHK : ((hit_deny || hit_allow) ? S_OUT : S_WALK_RD);
      S_WG_CHK:   state_d = !g_hit ? S_WG_RD : ((hit_deny || hit_allow) ? S_OUT : S_WALK_RD);
      S_OUT:      state_d = out_free ? S_IDLE : S_OUT;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    idx_d = idx_q;  s_d = s_q;  n_d = n_q;  gidx_d = gidx_q;
    ecount_d = ecount_q;  gcount_d = gcount_q;
    cur_d = cur_q;  req_d = req_q;  given_d = given_q;  sid_d = sid_q;
    keep_d = keep_q;  own_d = own_q;  ore_d = ore_q;
    pend_d = pend_q;  out_d = out_q;
    ov_d = ov_q && !rsp_o.ready;
    e_we = 1'b0;  e_waddr = idx_q[EAW-1:0];  e_wdata = cur_q;
    g_we = 1'b0;  g_waddr = gidx_q[GAW-1:0];  g_wdata = g_rdata_q;
    e_raddr = idx_q[EAW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pend_d = '{status: ST_OK, granted: 1'b0, reason: RSN_NONE,
                     granted_rights: 7'd0, missing_rights: 7'd0,
                     deciding_entry: NO_ENTRY};
          sid_d  = sid_m;
          req_d  = req_i.rights;
          keep_d = req_i.keep_inherited;
          gidx_d = '0;
          idx_d  = '0;
          n_d    = '0;
          own_d  = user_q == owner_q;
          ore_d  = 1'b0;
          unique case (req_i.mode)
            MODE_CLEAR: begin
              ecount_d = '0;
              gcount_d = '0;
            end
            MODE_ADD_GROUP: begin
              if (g_full) begin
                pend_d.status = ST_FULL;
              end else begin
                g_we     = 1'b1;
                g_waddr  = gcount_q[GAW-1:0];
                g_wdata  = '{id: sid_m, deny_only: 1'b0};
                gcount_d = gcount_q + GCW'(1);
              end
            end
            MODE_ADD_ENTRY: begin
              if (e_full) begin
                pend_d.status = ST_FULL;
              end else begin
                e_we     = 1'b1;
                e_waddr  = ecount_q[EAW-1:0];
                e_wdata  = '{id: sid_m, rights: req_i.rights, deny: req_i.is_deny,
                             inh: req_i.inherited};
                ecount_d = ecount_q + ECW'(1);
              end
            end
            MODE_SORT: idx_d = ECW'(1);
            MODE_EVAL: begin
              if (req_i.rights == 7'd0) begin
                pend_d.status = ST_EMPTY_MASK;
              end else if (integ_fail) begin
                pend_d.reason = RSN_INTEGRITY;
                pend_d.missing_rights = req_i.rights & forbid;
              end
            end
            default: ;
          endcase
        end
      end
      S_MARK_CHK: begin
        if (g_rdata_q.id == sid_q) begin
          g_we    = 1'b1;
          g_wdata = '{id: g_rdata_q.id, deny_only: 1'b1};
        end
        gidx_d = gidx_q + GCW'(1);
      end
      S_SORT_E: begin
        cur_d   = e_rdata_q;
        s_d     = idx_q;
        e_raddr = EAW'(idx_q - ECW'(1));
      end
      S_SORT_J: begin
        e_raddr = EAW'(s_q - ECW'(2));
        e_we    = 1'b1;
        e_waddr = s_q[EAW-1:0];
        if (cls_gt) begin
          e_wdata = e_rdata_q;
          s_d     = s_q - ECW'(1);
        end else begin
          e_wdata = cur_q;
          idx_d   = idx_q + ECW'(1);
        end
      end
      S_SORT_PUT: begin
        e_we    = 1'b1;
        e_waddr = s_q[EAW-1:0];
        e_wdata = cur_q;
        idx_d   = idx_q + ECW'(1);
      end
      S_CUT_RD: begin
        if (e_end) ecount_d = n_q;
      end
      S_CUT_CHK: begin
        if (!(e_rdata_q.inh && !keep_q)) begin
          e_we    = 1'b1;
          e_waddr = n_q[EAW-1:0];
          e_wdata = '{id: e_rdata_q.id, rights: e_rdata_q.rights, deny: e_rdata_q.deny,
                      inh: 1'b0};
          n_d     = n_q + ECW'(1);
        end
        idx_d = idx_q + ECW'(1);
      end
      S_OWN_CHK: begin
        if (!g_rdata_q.deny_only && (g_rdata_q.id == owner_q)) own_d = 1'b1;
        gidx_d = gidx_q + GCW'(1);
      end
      S_ORE_CHK: begin
        if (e_rdata_q.id == ID_OWNER_RIGHTS) ore_d = 1'b1;
        idx_d = idx_q + ECW'(1);
      end
      S_PRE: begin
        given_d = pre_given;
        idx_d   = '0;
        if (pre_given == req_q) begin
          pend_d.granted = 1'b1;
          pend_d.reason  = RSN_OWNER;
          pend_d.granted_rights = req_q;
        end else if (null_q) begin
          pend_d.granted = 1'b1;
          pend_d.reason  = RSN_NULL;
          pend_d.granted_rights = req_q;
        end else if (ecount_q == '0) begin
          pend_d.reason = RSN_EMPTY;
          pend_d.granted_rights = pre_given;
          pend_d.missing_rights = req_q & ~pre_given;
        end
      end
      S_WALK_RD: begin
        if (e_end) begin
          pend_d.reason = RSN_EXHAUSTED;
          pend_d.granted_rights = given_q;
          pend_d.missing_rights = req_q & ~given_q;
        end
      end
      S_WG_CHK: begin
        if (!g_hit) gidx_d = gidx_q + GCW'(1);
      end
      S_OUT: begin
        if (out_free) begin
          out_d = pend_q;
          ov_d  = 1'b1;
        end
      end
      default: ;
    endcase

    if (state_q == S_WALK_CHK) begin
      cur_d  = e_rdata_q;
      gidx_d = '0;
    end
    if (apply_now) begin
      if (hit_deny) begin
        pend_d.reason = RSN_DENY;
        pend_d.granted_rights = given_q;
        pend_d.missing_rights = refused;
        pend_d.deciding_entry = 6'(idx_q);
      end else if (hit_allow) begin
        pend_d.granted = 1'b1;
        pend_d.reason  = RSN_ALLOWS;
        pend_d.granted_rights = req_q;
        pend_d.deciding_entry = 6'(idx_q);
      end else begin
        if ((m == M_FULL) && !ent_cur.deny) given_d = given_new;
        idx_d = idx_q + ECW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ecount_q <= '0;
      gcount_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      ecount_q <= ecount_d;
      gcount_q <= gcount_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    s_q     <= s_d;
    n_q     <= n_d;
    gidx_q  <= gidx_d;
    cur_q   <= cur_d;
    req_q   <= req_d;
    given_q <= given_d;
    sid_q   <= sid_d;
    keep_q  <= keep_d;
    own_q   <= own_d;
    ore_q   <= ore_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign req_i.ready           = state_q == S_IDLE;
  assign rsp_o.valid           = ov_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.access_granted  = out_q.granted;
  assign rsp_o.decision_reason = out_q.reason;
  assign rsp_o.granted_rights  = out_q.granted_rights;
  assign rsp_o.missing_rights  = out_q.missing_rights;
  assign rsp_o.deciding_entry  = out_q.deciding_entry;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecount_q <= ECW'(ENTRY_DEPTH) && gcount_q <= GCW'(GROUP_DEPTH))
    else $error("table count beyond depth");

  a_grant_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.access_granted |->
      rsp_o.missing_rights == 7'd0 && rsp_o.status == ST_OK)
    else $error("granted item with missing rights");

  a_entry_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.deciding_entry != NO_ENTRY |->
      rsp_o.decision_reason == RSN_DENY || rsp_o.decision_reason == RSN_ALLOWS)
    else $error("deciding entry without entry reason");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted item left no work");

endmodule

// ===== tb/acl_tb_checker.sv =====
// checker of the access check engine: predicts one response per accepted request item
// and compares it with the observed response; depends on acl_pkg and acl_if.sv
module acl_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  acl_req_if.sink     req,
  acl_rsp_if.sink     rsp,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import acl_pkg::*;

  localparam int NE = 32;
  localparam int NG = 16;

  entry_t     acl_list [NE];
  int         acl_len;
  group_t     token_groups [NG];
  int         group_len;
  logic [15:0] user_q, owner_q;
  logic [1:0]  token_q, label_q;
  logic        nru_q, priv_q, null_q;
  rsp_t        pending_rsp [$];

  function automatic logic is_owner();
    if (user_q == owner_q) return 1'b1;
    for (int i = 0; i < group_len; i++)
      if (!token_groups[i].deny_only && token_groups[i].id == owner_q) return 1'b1;
    return 1'b0;
  endfunction

  function automatic match_e id_match(logic [15:0] id);
    if (id == ID_EVERYONE || id == user_q) return M_FULL;
    if (id == ID_OWNER_RIGHTS) return is_owner() ? M_FULL : M_NONE;
    for (int i = 0; i < group_len; i++)
      if (token_groups[i].id == id) return token_groups[i].deny_only ? M_DENY_ONLY : M_FULL;
    return M_NONE;
  endfunction

  function automatic logic [1:0] cls(entry_t e);
    return {e.inh, ~e.deny};
  endfunction

  function automatic rsp_t decide(logic [6:0] req_r);
    rsp_t r;
    logic [6:0] given, forbid, refused;
    logic ore;
    match_e m;
    r = '0;
    r.deciding_entry = 6'(NE);
    given = '0;
    if (token_q < label_q) begin
      forbid = WRITE_KIND | (nru_q ? READ_EXEC : 7'd0);
      if ((req_r & forbid) != 7'd0) begin
        r.reason = RSN_INTEGRITY;
        r.missing_rights = req_r & forbid;
        return r;
      end
    end
    if (((req_r & TAKE_OWNER) != 7'd0) && priv_q) given |= TAKE_OWNER;
    ore = 1'b0;
    for (int i = 0; i < acl_len; i++) if (acl_list[i].id == ID_OWNER_RIGHTS) ore = 1'b1;
    if (is_owner() && !ore) given |= req_r & OWNER_IMPLICIT;
    if (given == req_r) begin
      r.granted = 1'b1; r.reason = RSN_OWNER; r.granted_rights = req_r;
      return r;
    end
    if (null_q) begin
      r.granted = 1'b1; r.reason = RSN_NULL; r.granted_rights = req_r;
      return r;
    end
    if (acl_len == 0) begin
      r.reason = RSN_EMPTY; r.granted_rights = given; r.missing_rights = req_r & ~given;
      return r;
    end
    for (int i = 0; i < acl_len; i++) begin
      m = id_match(acl_list[i].id);
      if (m == M_NONE || (m == M_DENY_ONLY && !acl_list[i].deny)) continue;
      if (acl_list[i].deny) begin
        refused = acl_list[i].rights & req_r & ~given;
        if (refused != 7'd0) begin
          r.reason = RSN_DENY; r.granted_rights = given; r.missing_rights = refused;
          r.deciding_entry = 6'(i);
          return r;
        end
        continue;
      end
      given |= acl_list[i].rights & req_r;
      if (given == req_r) begin
        r.granted = 1'b1; r.reason = RSN_ALLOWS; r.granted_rights = req_r;
        r.deciding_entry = 6'(i);
        return r;
      end
    end
    r.reason = RSN_EXHAUSTED; r.granted_rights = given; r.missing_rights = req_r & ~given;
    return r;
  endfunction

  function automatic rsp_t apply_request(mode_e mode, logic [15:0] sid, logic [6:0] rt,
                                         logic dn, logic inh, logic keep);
    rsp_t r;
    entry_t e;
    int j, n;
    r = '0;
    r.deciding_entry = 6'(NE);
    case (mode)
      MODE_CLEAR: begin
        acl_len = 0; group_len = 0;
      end
      MODE_ADD_GROUP: begin
        if (group_len >= NG) r.status = ST_FULL;
        else begin
          token_groups[group_len] = '{id: sid, deny_only: 1'b0};
          group_len++;
        end
      end
      MODE_MARK: begin
        for (int i = 0; i < group_len; i++)
          if (token_groups[i].id == sid) token_groups[i].deny_only = 1'b1;
      end
      MODE_ADD_ENTRY: begin
        if (acl_len >= NE) r.status = ST_FULL;
        else begin
          acl_list[acl_len] = '{id: sid, rights: rt, deny: dn, inh: inh};
          acl_len++;
        end
      end
      MODE_SORT: begin
        for (int i = 1; i < acl_len; i++) begin
          e = acl_list[i];
          j = i - 1;
          while (j >= 0 && cls(acl_list[j]) > cls(e)) begin
            acl_list[j + 1] = acl_list[j];
            j--;
          end
          acl_list[j + 1] = e;
        end
      end
      MODE_CUT: begin
        n = 0;
        for (int i = 0; i < acl_len; i++) begin
          if (acl_list[i].inh && !keep) continue;
          acl_list[n] = acl_list[i];
          acl_list[n].inh = 1'b0;
          n++;
        end
        acl_len = n;
      end
      MODE_EVAL: begin
        if (rt == 7'd0) r.status = ST_EMPTY_MASK;
        else r = decide(rt);
      end
      default: ;
    endcase
    return r;
  endfunction

  rsp_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acl_len = 0; group_len = 0;
      user_q <= '0; owner_q <= '0; token_q <= 2'd1; label_q <= 2'd1;
      nru_q <= 1'b0; priv_q <= 1'b0; null_q <= 1'b0;
      fail_count <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_USER:      user_q <= cfg_wdata_i;
          CFG_OWNER:     owner_q <= cfg_wdata_i;
          CFG_TOKEN_LVL: token_q <= cfg_wdata_i[1:0];
          CFG_OBJ_LABEL: label_q <= cfg_wdata_i[1:0];
          CFG_NO_RD_UP:  nru_q <= cfg_wdata_i[0];
          CFG_TAKE_PRIV: priv_q <= cfg_wdata_i[0];
          CFG_NULL_LIST: null_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.access_granted, rsp.decision_reason, rsp.granted_rights,
                rsp.missing_rights, rsp.deciding_entry};
        if (pending_rsp.size() == 0) begin
          if (fail_count < 10) $display("unexpected response %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_rsp.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (req.valid && req.ready)
        pending_rsp.push_back(apply_request(mode_e'(req.mode), req.sid, req.rights,
                                            req.is_deny, req.inherited, req.keep_inherited));
    end
  end

  assign pending_count = pending_rsp.size();
endmodule

// ===== tb/tb_acl_access_check_engine.sv =====
// top of the access check engine testbench: clock, reset, config writes and request
// stimulus; depends on acl_pkg, acl_if.sv, the engine and acl_tb_checker
module tb_acl_access_check_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import acl_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  int          fail_count, pending_count;
  int          hold_cycles;
  int          hold_req, hold_seen;
  logic        rand_stall;
  int          sent;

  acl_req_if req_ch ();
  acl_rsp_if rsp_ch ();

  acl_access_check_engine DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .req_i(req_ch.sink), .rsp_o(rsp_ch.source)
  );

  acl_tb_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .req(req_ch.sink), .rsp(rsp_ch.sink), .fail_count, .pending_count
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("** acl_access_check_engine: FAILED **");
    $finish;
  end

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 40)) :
                                         int'($urandom_range(0, 2));
  endfunction

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    rsp_ch.ready = 1'b0;
    hold_cycles = 0;
    hold_seen = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cycles = 1500;
      end
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rand_stall) begin
        rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_count != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_req(mode_e m, logic [15:0] sid, logic [6:0] rt,
                          logic dn, logic inh, logic keep, bit no_gap);
    int g;
    g = no_gap ? 0 : short_gap();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= m; req_ch.sid <= sid; req_ch.rights <= rt;
    req_ch.is_deny <= dn; req_ch.inherited <= inh; req_ch.keep_inherited <= keep;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic end_burst();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(2, 7));
    endcase
  endfunction

  task automatic random_config();
    cfg_write(CFG_USER, pick_id());
    cfg_write(CFG_OWNER, pick_id());
    cfg_write(CFG_TOKEN_LVL, 16'($urandom_range(0, 3)));
    cfg_write(CFG_OBJ_LABEL, 16'($urandom_range(0, 3)));
    cfg_write(CFG_NO_RD_UP, 16'($urandom_range(0, 1)));
    cfg_write(CFG_TAKE_PRIV, 16'($urandom_range(0, 1)));
    cfg_write(CFG_NULL_LIST, 16'($urandom_range(0, 5) == 0));
  endtask

  // one scenario: build groups and a list, maybe sort or cut, then evaluate
  task automatic random_scenario(bit fast);
    int ng, ne, nv;
    mode_e m;
    send_req(MODE_CLEAR, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
             1'($urandom), fast);
    ng = $urandom_range(0, 4);
    for (int i = 0; i < ng; i++)
      send_req(MODE_ADD_GROUP, pick_id(), 7'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom), fast);
    if ($urandom_range(0, 1))
      send_req(MODE_MARK, pick_id(), 7'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom), fast);
    ne = $urandom_range(0, 6);
    for (int i = 0; i < ne; i++)
      send_req(MODE_ADD_ENTRY, pick_id(), 7'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom), fast);
    if ($urandom_range(0, 2) == 0)
      send_req(MODE_SORT, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom), fast);
    if ($urandom_range(0, 3) == 0)
      send_req(MODE_CUT, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom_range(0, 1)), fast);
    nv = $urandom_range(1, 4);
    for (int i = 0; i < nv; i++) begin
      m = ($urandom_range(0, 9) == 0) ? mode_e'(3'($urandom_range(0, 7))) : MODE_EVAL;
      send_req(m, pick_id(), ($urandom_range(0, 15) == 0) ? 7'd0 : 7'($urandom),
               1'($urandom), 1'($urandom), 1'($urandom), fast);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    sent = 0;
    hold_req = 0;
    rand_stall = 1'b1;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    req_ch.valid = 1'b0; req_ch.mode = '0; req_ch.sid = '0; req_ch.rights = '0;
    req_ch.is_deny = 1'b0; req_ch.inherited = 1'b0; req_ch.keep_inherited = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults, then owner, integrity, deny-only, sort and cut, group overflow and null list
    send_req(MODE_EVAL, 16'd0, 7'h7F, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_NOP, 16'hFFFF, 7'h7F, 1'b1, 1'b1, 1'b1, 1'b0);
    end_burst();
    wait_idle();
    cfg_write(CFG_USER, 16'd5);
    cfg_write(CFG_OWNER, 16'd9);
    cfg_write(CFG_TOKEN_LVL, 16'd0);
    cfg_write(CFG_OBJ_LABEL, 16'd3);
    cfg_write(CFG_NO_RD_UP, 16'd1);
    cfg_write(CFG_TAKE_PRIV, 16'd1);
    cfg_write(CFG_NULL_LIST, 16'd0);
    send_req(MODE_EVAL, 16'd0, 7'h01, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h10, 1'b0, 1'b0, 1'b0, 1'b0);
    end_burst();
    wait_idle();
    cfg_write(CFG_TOKEN_LVL, 16'd3);
    send_req(MODE_ADD_GROUP, 16'd9, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_ADD_GROUP, 16'd7, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_MARK, 16'd7, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_MARK, 16'd1234, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h70, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_ADD_ENTRY, 16'd7, 7'h02, 1'b0, 1'b1, 1'b0, 1'b0);
    send_req(MODE_ADD_ENTRY, 16'd7, 7'h04, 1'b1, 1'b1, 1'b0, 1'b0);
    send_req(MODE_ADD_ENTRY, 16'd1, 7'h01, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_ADD_ENTRY, 16'hFFFF, 7'h7F, 1'b1, 1'b0, 1'b0, 1'b0);
    send_req(MODE_ADD_ENTRY, 16'd0, 7'h08, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h7F, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h0D, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_SORT, 16'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h0D, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_CUT, 16'd0, 7'd0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_req(MODE_CUT, 16'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h09, 1'b0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 18; i++)
      send_req(MODE_ADD_GROUP, 16'(i), 7'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    end_burst();
    wait_idle();
    cfg_write(CFG_NULL_LIST, 16'd1);
    send_req(MODE_EVAL, 16'd0, 7'h03, 1'b0, 1'b0, 1'b0, 1'b0);
    end_burst();
    wait_idle();

    // fill the entry table under a long receiver hold-off
    hold_req++;
    for (int i = 0; i < 34; i++)
      send_req(MODE_ADD_ENTRY, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
               1'b0, 1'b1);
    send_req(MODE_SORT, 16'd0, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1);
    send_req(MODE_CUT, 16'd0, 7'd0, 1'b0, 1'b0, 1'b1, 1'b1);
    end_burst();
    wait_idle();
    cfg_write(CFG_NULL_LIST, 16'd0);
    cfg_write(CFG_USER, 16'hFFFF);
    send_req(MODE_EVAL, 16'd0, 7'h7F, 1'b0, 1'b0, 1'b0, 1'b0);
    send_req(MODE_EVAL, 16'd0, 7'h7F, 1'b0, 1'b0, 1'b0, 1'b0);
    end_burst();
    wait_idle();

    while (sent < 830) begin
      random_config();
      rand_stall = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 3; k++)
        random_scenario($urandom_range(0, 4) == 0);
      end_burst();
      wait_idle();
    end

    wait_idle();
    if (fail_count == 0) $display("** acl_access_check_engine: PASSED **");
    else $display("** acl_access_check_engine: FAILED **");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/acl_pkg.sv
hdl/acl_if.sv
hdl/acl_access_check_engine.sv
tb/acl_tb_checker.sv
tb/tb_acl_access_check_engine.sv
